// ===== sv/double_ended_queue_top_macros.svh =====
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("double-ended queue assertion failed");

`define DEQ_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define DEQ_ASSERT(lbl, clk, rst_n, prop)

`define DEQ_ASSERT_MSG(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ===== sv/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int DEPTH_DEF      = 16;

    localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [4:0]  entry_count;
        logic        is_empty;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== sv/deq_mem.sv =====
`default_nettype none

module deq_mem #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]         i_raddr_f,
    input  wire logic [AW-1:0]         i_raddr_b,
    output logic      [DATA_WIDTH-1:0] o_rdata_f,
    output logic      [DATA_WIDTH-1:0] o_rdata_b
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_f <= r_mem[i_raddr_f];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== sv/deq_ctrl.sv =====
`default_nettype none

module deq_ctrl #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire deq_pkg::t_in_item     i_item,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output deq_pkg::t_out_item         o_item,
    output logic                       o_we,
    output logic      [AW-1:0]         o_waddr,
    output logic      [DATA_WIDTH-1:0] o_wdata,
    output logic      [AW-1:0]         o_raddr_f,
    output logic      [AW-1:0]         o_raddr_b,
    input  wire logic [DATA_WIDTH-1:0] i_rdata_f,
    input  wire logic [DATA_WIDTH-1:0] i_rdata_b
);

    deq_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_front, n_front;
    logic [AW-1:0]      r_back, n_back;
    logic [CW-1:0]      r_count, n_count;
    logic [1:0]         r_status, n_status;
    logic               r_out_valid;
    deq_pkg::t_out_item r_out;

    logic          accept;
    logic          full;
    logic          empty;
    logic [AW-1:0] front_next;
    logic [AW-1:0] front_prev;
    logic [AW-1:0] back_prev;
    logic          load;

    assign accept     = i_valid && (r_state == deq_pkg::S_IDLE);
    assign o_stall    = (r_state != deq_pkg::S_IDLE);
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign front_next = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign front_prev = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign back_prev  = (r_back == '0) ? AW'(DEPTH - 1) : r_back - AW'(1);
    assign load       = (r_state == deq_pkg::S_LOAD) && (!r_out_valid || !i_stall);

    assign o_wdata   = DATA_WIDTH'(i_item.entry_value);
    assign o_raddr_f = r_front;
    assign o_raddr_b = back_prev;

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_back;
        if (accept) begin
            n_status = deq_pkg::ST_DONE;
            case (i_item.action)
                deq_pkg::ACT_PUSH_BACK: begin
                    if (full) begin
                        n_status = deq_pkg::ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = r_back;
                        n_back  = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + AW'(1);
                        n_count = r_count + CW'(1);
                    end
                end
                deq_pkg::ACT_PUSH_FRONT: begin
                    if (full) begin
                        n_status = deq_pkg::ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = front_prev;
                        n_front = front_prev;
                        n_count = r_count + CW'(1);
                    end
                end
                deq_pkg::ACT_POP_FRONT: begin
                    if (empty) begin
                        n_status = deq_pkg::ST_EMPTY;
                    end else begin
                        n_front = front_next;
                        n_count = r_count - CW'(1);
                    end
                end
                deq_pkg::ACT_POP_BACK: begin
                    if (empty) begin
                        n_status = deq_pkg::ST_EMPTY;
                    end else begin
                        n_back  = back_prev;
                        n_count = r_count - CW'(1);
                    end
                end
                deq_pkg::ACT_CLEAR: begin
                    n_front = '0;
                    n_back  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = deq_pkg::S_READ;
                end
            end
            deq_pkg::S_READ: begin
                n_state = deq_pkg::S_LOAD;
            end
            deq_pkg::S_LOAD: begin
                if (load) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_status    <= deq_pkg::ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_back   <= n_back;
            r_count  <= n_count;
            r_status <= n_status;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.status      <= r_status;
            r_out.front_value <= empty ? '0 : 32'(i_rdata_f);
            r_out.back_value  <= empty ? '0 : 32'(i_rdata_b);
            r_out.entry_count <= 5'(r_count);
            r_out.is_empty    <= empty;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_top.sv =====
// Bounded double-ended queue held in a circular on-chip memory.
// The input channel (i_valid, o_stall, i_item) carries one action per beat:
// push at the back, push at the front, pop at the front, pop at the back or
// clear. The output channel (o_valid, i_stall, o_item) returns one result
// beat per action with the status, the front and back elements after the
// action, the element count and an empty flag.
// An accepted action passes through these steps in order: the accepting
// edge updates the pointers and writes the memory, the memory read then
// registers the front and back entries, and the load step fills the output
// register. A new action is not taken until the current one has left the
// load step; the memory read of the front and back entries that follows
// each update is one of the steps that it waits for.
// When the receiver stalls, the result holds in the output register and the
// next action is still accepted and processed; it waits in the load step
// until the output register is free.
// Reset empties the queue and drops any pending result; the memory contents
// are not cleared, since no entry is read before it has been written.
`default_nettype none

`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = deq_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire deq_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output deq_pkg::t_out_item     o_item
);

    localparam int AW = $clog2(DEPTH);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr_f;
    logic [AW-1:0]         mem_raddr_b;
    logic [DATA_WIDTH-1:0] mem_rdata_f;
    logic [DATA_WIDTH-1:0] mem_rdata_b;
    logic                  res_empty;
    logic                  res_count_zero;
    logic                  res_values_zero;

    deq_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item),
        .o_we      (mem_we),
        .o_waddr   (mem_waddr),
        .o_wdata   (mem_wdata),
        .o_raddr_f (mem_raddr_f),
        .o_raddr_b (mem_raddr_b),
        .i_rdata_f (mem_rdata_f),
        .i_rdata_b (mem_rdata_b)
    );

    deq_mem #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_f (mem_raddr_f),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_f (mem_rdata_f),
        .o_rdata_b (mem_rdata_b)
    );

    assign res_empty       = o_valid && o_item.is_empty;
    assign res_count_zero  = (o_item.entry_count == 5'd0);
    assign res_values_zero = (o_item.front_value == 32'd0) && (o_item.back_value == 32'd0);

    `DEQ_ASSERT(a_accept_blocks, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)
    `DEQ_ASSERT(a_no_write_idle, i_clk, i_rst_n, mem_we |-> (i_valid && !o_stall))
    `DEQ_ASSERT_MSG(a_empty_count, i_clk, i_rst_n, res_empty |-> res_count_zero, "nonzero count")
    `DEQ_ASSERT_MSG(a_empty_zero, i_clk, i_rst_n, res_empty |-> res_values_zero, "nonzero values")

endmodule

`default_nettype wire
